// ----- design/foccl_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and the sine table generator for the foc current loop
// no dependencies; imported by foccl_serial_mul and foc_current_loop
package foccl_pkg;

  typedef struct packed {
    logic signed [15:0] phase_a_current;
    logic signed [15:0] phase_b_current;
    logic [15:0]        rotor_angle;
  } foccl_in_t;

  typedef struct packed {
    logic signed [15:0] d_voltage;
    logic signed [15:0] q_voltage;
    logic signed [15:0] d_current;
    logic signed [15:0] q_current;
    logic               saturated;
  } foccl_out_t;

  // configuration register indexes
  localparam logic [2:0] REG_D_REF = 3'd0;
  localparam logic [2:0] REG_Q_REF = 3'd1;
  localparam logic [2:0] REG_D_KP  = 3'd2;
  localparam logic [2:0] REG_D_KI  = 3'd3;
  localparam logic [2:0] REG_Q_KP  = 3'd4;
  localparam logic [2:0] REG_Q_KI  = 3'd5;

  // multiplier operand lengths in bits
  localparam logic [1:0] LEN16 = 2'd0;
  localparam logic [1:0] LEN24 = 2'd1;
  localparam logic [1:0] LEN32 = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] len;
  } mul_ctl_t;

  localparam logic [15:0] INV_SQRT3_Q16 = 16'd37837;
  localparam logic [63:0] TWO_PI_Q30    = 64'd6746518852;
  localparam logic [63:0] ONE_Q30       = 64'd1073741824;

  // quarter-wave sine magnitude in q14, odd taylor series in q30
  function automatic logic [14:0] sine_mag(input int unsigned r, input int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    x  = (64'(r) * TWO_PI_Q30) >> bits;
    x2 = (x * x) >> 30;
    t  = ONE_Q30 - x2 / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    v  = (s + 64'd32768) >> 16;
    return v[14:0];
  endfunction

endpackage

// ----- design/foccl_serial_mul.sv -----
`timescale 1ns / 1ps
// bit-serial unsigned shift-add multiplier, one multiplier bit per cycle
// depends on foccl_pkg for the control struct and length codes
module foccl_serial_mul #(
  parameter int MW = 40
) (
  input  logic                clk,
  input  logic                rst,
  input  foccl_pkg::mul_ctl_t ctl,
  input  logic [MW-1:0]       mcand,
  input  logic [31:0]         mplier,
  output logic                done,
  output logic [MW+31:0]      product
);
  import foccl_pkg::*;

  localparam int PW = MW + 32;

  logic [PW-1:0] p;
  logic [MW-1:0] a;
  logic [1:0]    len;
  logic [5:0]    cnt;
  logic [5:0]    cnt_start;
  logic          busy;
  logic [MW:0]   sum;

  assign sum = {1'b0, p[PW-1:32]} + (p[0] ? {1'b0, a} : {(MW+1){1'b0}});

  always_comb begin
    unique case (ctl.len)
      LEN16:   cnt_start = 6'd16;
      LEN24:   cnt_start = 6'd24;
      default: cnt_start = 6'd32;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= cnt_start;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      p   <= {{MW{1'b0}}, mplier};
      a   <= mcand;
      len <= ctl.len;
    end else if (busy) begin
      p <= {sum, p[31:1]};
    end
  end

  // a short multiplier leaves the product shifted up by the unused bits
  always_comb begin
    unique case (len)
      LEN16:   product = p >> 16;
      LEN24:   product = p >> 8;
      default: product = p;
    endcase
  end

endmodule

// ----- design/foc_current_loop.sv -----
`timescale 1ns / 1ps
// clarke/park transform and two pi current regulators, one result per sample
// a sample is taken only in idle, so a new one waits until the last is through
// its nine passes through the single bit-serial multiplier
// (16, 16, 16, 16, 16, 24, 32, 24, 32 bits). the output register lets the next
// sample start while a result waits. synchronous reset returns the config
// registers to their defaults and clears both integrators
module foc_current_loop #(
  parameter int SINE_TABLE_BITS  = 10,
  parameter int INTEGRATOR_WIDTH = 40
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  foccl_pkg::foccl_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output foccl_pkg::foccl_out_t out_data,
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  import foccl_pkg::*;

  localparam int STB = SINE_TABLE_BITS;
  localparam int IW  = INTEGRATOR_WIDTH;
  localparam int QN  = 1 << (STB - 2);
  localparam int MW  = IW;
  localparam int PW  = MW + 32;
  localparam int RFW = (IW + 1 > 42) ? IW + 1 : 42;
  localparam logic [40:0] ILIM = 41'h100_0000_0000;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MB   = 5'd1;
  localparam logic [4:0] S_WB   = 5'd2;
  localparam logic [4:0] S_M1   = 5'd3;
  localparam logic [4:0] S_W1   = 5'd4;
  localparam logic [4:0] S_M2   = 5'd5;
  localparam logic [4:0] S_W2   = 5'd6;
  localparam logic [4:0] S_FD   = 5'd7;
  localparam logic [4:0] S_M3   = 5'd8;
  localparam logic [4:0] S_W3   = 5'd9;
  localparam logic [4:0] S_M4   = 5'd10;
  localparam logic [4:0] S_W4   = 5'd11;
  localparam logic [4:0] S_FQ   = 5'd12;
  localparam logic [4:0] S_INT  = 5'd13;
  localparam logic [4:0] S_MPD  = 5'd14;
  localparam logic [4:0] S_WPD  = 5'd15;
  localparam logic [4:0] S_MID  = 5'd16;
  localparam logic [4:0] S_WID  = 5'd17;
  localparam logic [4:0] S_MPQ  = 5'd18;
  localparam logic [4:0] S_WPQ  = 5'd19;
  localparam logic [4:0] S_MIQ  = 5'd20;
  localparam logic [4:0] S_WIQ  = 5'd21;
  localparam logic [4:0] S_DONE = 5'd22;

  logic [4:0] state;

  // configuration
  logic signed [15:0] d_ref, q_ref;
  logic [23:0]        d_kp, q_kp;
  logic [31:0]        d_ki, q_ki;

  // datapath
  logic signed [15:0]   ia;
  logic [STB-1:0]       kk;
  logic signed [17:0]   s;
  logic                 beta_neg;
  logic [16:0]          beta_mag;
  logic signed [31:0]   sum;
  logic signed [15:0]   id, iq;
  logic signed [16:0]   err_d, err_q;
  logic signed [IW-1:0] acc_d, acc_q;
  logic signed [26:0]   pterm;
  logic signed [15:0]   vd, vq;
  logic                 flag;

  // sine table, quarter wave plus its end point
  logic [14:0] qtab [QN+1];
  for (genvar i = 0; i <= QN; i++) begin : g_tab
    assign qtab[i] = sine_mag(i, STB);
  end

  logic [STB-1:0] kc;
  logic [STB-2:0] sn_idx, cs_idx;
  logic [14:0]    sn_mag, cs_mag;
  logic           sn_neg, cs_neg;

  always_comb begin
    kc     = kk + STB'(QN);
    sn_idx = kk[STB-2] ? (STB-1)'(QN) - {1'b0, kk[STB-3:0]} : {1'b0, kk[STB-3:0]};
    cs_idx = kc[STB-2] ? (STB-1)'(QN) - {1'b0, kc[STB-3:0]} : {1'b0, kc[STB-3:0]};
    sn_mag = qtab[sn_idx];
    cs_mag = qtab[cs_idx];
    sn_neg = kk[STB-1];
    cs_neg = kc[STB-1];
  end

  // magnitudes for the unsigned multiplier
  logic [16:0]   s_mag;
  logic [15:0]   ia_mag;
  logic [16:0]   ed_mag, eq_mag;
  logic [IW-1:0] accd_mag, accq_mag;

  assign s_mag    = s[17] ? 17'(-s) : 17'(s);
  assign ia_mag   = ia[15] ? 16'(-ia) : 16'(ia);
  assign ed_mag   = err_d[16] ? 17'(-err_d) : 17'(err_d);
  assign eq_mag   = err_q[16] ? 17'(-err_q) : 17'(err_q);
  assign accd_mag = acc_d[IW-1] ? IW'(-acc_d) : IW'(acc_d);
  assign accq_mag = acc_q[IW-1] ? IW'(-acc_q) : IW'(acc_q);

  mul_ctl_t     mctl;
  logic [MW-1:0] mcand;
  logic [31:0]   mplier;
  logic          mul_done;
  logic [PW-1:0] product;

  always_comb begin
    mctl.start = 1'b0;
    mctl.len   = LEN16;
    mcand      = '0;
    mplier     = '0;
    unique case (state)
      S_MB: begin
        mctl.start = 1'b1;
        mcand      = MW'(s_mag);
        mplier     = 32'(INV_SQRT3_Q16);
      end
      S_M1: begin
        mctl.start = 1'b1;
        mcand      = MW'(ia_mag);
        mplier     = 32'(cs_mag);
      end
      S_M2: begin
        mctl.start = 1'b1;
        mcand      = MW'(beta_mag);
        mplier     = 32'(sn_mag);
      end
      S_M3: begin
        mctl.start = 1'b1;
        mcand      = MW'(beta_mag);
        mplier     = 32'(cs_mag);
      end
      S_M4: begin
        mctl.start = 1'b1;
        mcand      = MW'(ia_mag);
        mplier     = 32'(sn_mag);
      end
      S_MPD: begin
        mctl.start = 1'b1;
        mctl.len   = LEN24;
        mcand      = MW'(ed_mag);
        mplier     = 32'(d_kp);
      end
      S_MID: begin
        mctl.start = 1'b1;
        mctl.len   = LEN32;
        mcand      = accd_mag;
        mplier     = d_ki;
      end
      S_MPQ: begin
        mctl.start = 1'b1;
        mctl.len   = LEN24;
        mcand      = MW'(eq_mag);
        mplier     = 32'(q_kp);
      end
      S_MIQ: begin
        mctl.start = 1'b1;
        mctl.len   = LEN32;
        mcand      = accq_mag;
        mplier     = q_ki;
      end
      default: ;
    endcase
  end

  foccl_serial_mul #(
    .MW(MW)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mctl),
    .mcand   (mcand),
    .mplier  (mplier),
    .done    (mul_done),
    .product (product)
  );

  // park product with its sign
  logic               park_neg;
  logic signed [31:0] pp, park_term;

  always_comb begin
    unique case (state)
      S_W1:    park_neg = ia[15] ^ cs_neg;
      S_W2:    park_neg = beta_neg ^ sn_neg;
      S_W3:    park_neg = beta_neg ^ cs_neg;
      default: park_neg = ia[15] ^ sn_neg;
    endcase
    pp        = $signed({1'b0, product[30:0]});
    park_term = park_neg ? -pp : pp;
  end

  // round the q26 park sum to q12 and saturate
  logic [31:0]        sum_mag;
  logic [18:0]        r14;
  logic signed [15:0] cur_val;
  logic               cur_of;

  always_comb begin
    sum_mag = sum[31] ? 32'(-sum) : 32'(sum);
    r14     = 19'((33'(sum_mag) + 33'd8192) >> 14);
    cur_of  = 1'b0;
    if (!sum[31]) begin
      if (r14 > 19'd32767) begin
        cur_val = 16'sd32767;
        cur_of  = 1'b1;
      end else begin
        cur_val = 16'(r14);
      end
    end else begin
      if (r14 > 19'd32768) begin
        cur_val = -16'sd32768;
        cur_of  = 1'b1;
      end else begin
        cur_val = 16'(-r14);
      end
    end
  end

  // errors and saturating integrators
  logic signed [16:0]   ed, eq;
  logic signed [IW:0]   sd, sq;
  logic signed [IW-1:0] accd_next, accq_next;
  logic                 ovf_d, ovf_q;

  localparam logic [IW-1:0] ACC_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic [IW-1:0] ACC_MIN = {1'b1, {(IW-1){1'b0}}};

  always_comb begin
    ed    = 17'(d_ref) - 17'(id);
    eq    = 17'(q_ref) - 17'(iq);
    sd    = (IW+1)'(acc_d) + (IW+1)'(ed);
    sq    = (IW+1)'(acc_q) + (IW+1)'(eq);
    ovf_d = sd[IW] != sd[IW-1];
    ovf_q = sq[IW] != sq[IW-1];
    if (ovf_d) accd_next = sd[IW] ? ACC_MIN : ACC_MAX;
    else       accd_next = sd[IW-1:0];
    if (ovf_q) accq_next = sq[IW] ? ACC_MIN : ACC_MAX;
    else       accq_next = sq[IW-1:0];
  end

  // proportional and integral terms
  logic [25:0]        pmag;
  logic               err_neg, acc_neg;
  logic [RFW-1:0]     rfull;
  logic [40:0]        rclip;
  logic signed [42:0] rterm, vsum;
  logic signed [15:0] v_val;
  logic               v_of;

  always_comb begin
    err_neg = (state == S_WPQ) ? err_q[16] : err_d[16];
    acc_neg = (state == S_WIQ) ? acc_q[IW-1] : acc_d[IW-1];
    pmag    = 26'((42'(product[40:0]) + 42'd32768) >> 16);
    rfull   = RFW'(({1'b0, product} + (PW+1)'(33'h0_8000_0000)) >> 32);
    rclip   = (rfull > RFW'(ILIM)) ? ILIM : rfull[40:0];
    rterm   = acc_neg ? -$signed({2'b00, rclip}) : $signed({2'b00, rclip});
    vsum    = 43'(pterm) + rterm;
    v_of    = 1'b0;
    if (vsum > 43'sd32767) begin
      v_val = 16'sd32767;
      v_of  = 1'b1;
    end else if (vsum < -43'sd32768) begin
      v_val = -16'sd32768;
      v_of  = 1'b1;
    end else begin
      v_val = vsum[15:0];
    end
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // control: sequencer, output valid, configuration, integrators
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      d_ref     <= 16'sd4096;
      q_ref     <= 16'sd0;
      d_kp      <= 24'd6554;
      d_ki      <= 32'd42950;
      q_kp      <= 24'd6554;
      q_ki      <= 32'd42950;
      acc_d     <= '0;
      acc_q     <= '0;
    end else begin
      // the done state reloads the output register itself
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_D_REF: d_ref <= cfg_data[15:0];
          REG_Q_REF: q_ref <= cfg_data[15:0];
          REG_D_KP:  d_kp  <= cfg_data[23:0];
          REG_D_KI:  d_ki  <= cfg_data;
          REG_Q_KP:  q_kp  <= cfg_data[23:0];
          REG_Q_KI:  q_ki  <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_valid) state <= S_MB;
        S_MB:   state <= S_WB;
        S_WB:   if (mul_done) state <= S_M1;
        S_M1:   state <= S_W1;
        S_W1:   if (mul_done) state <= S_M2;
        S_M2:   state <= S_W2;
        S_W2:   if (mul_done) state <= S_FD;
        S_FD:   state <= S_M3;
        S_M3:   state <= S_W3;
        S_W3:   if (mul_done) state <= S_M4;
        S_M4:   state <= S_W4;
        S_W4:   if (mul_done) state <= S_FQ;
        S_FQ:   state <= S_INT;
        S_INT: begin
          acc_d <= accd_next;
          acc_q <= accq_next;
          state <= S_MPD;
        end
        S_MPD:  state <= S_WPD;
        S_WPD:  if (mul_done) state <= S_MID;
        S_MID:  state <= S_WID;
        S_WID:  if (mul_done) state <= S_MPQ;
        S_MPQ:  state <= S_WPQ;
        S_WPQ:  if (mul_done) state <= S_MIQ;
        S_MIQ:  state <= S_WIQ;
        S_WIQ:  if (mul_done) state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ia   <= in_data.phase_a_current;
          kk   <= in_data.rotor_angle[15:16-STB];
          s    <= 18'(in_data.phase_a_current) + 18'(in_data.phase_b_current)
                  + 18'(in_data.phase_b_current);
          flag <= 1'b0;
        end
      end
      S_WB: begin
        if (mul_done) begin
          beta_mag <= 17'((33'(product[32:0]) + 33'd32768) >> 16);
          beta_neg <= s[17];
        end
      end
      S_W1, S_W3: if (mul_done) sum <= park_term;
      S_W2:       if (mul_done) sum <= sum + park_term;
      S_W4:       if (mul_done) sum <= sum - park_term;
      S_FD: begin
        id   <= cur_val;
        flag <= flag | cur_of;
      end
      S_FQ: begin
        iq   <= cur_val;
        flag <= flag | cur_of;
      end
      S_INT: begin
        err_d <= ed;
        err_q <= eq;
        flag  <= flag | ovf_d | ovf_q;
      end
      S_WPD, S_WPQ: begin
        if (mul_done) pterm <= err_neg ? -27'(pmag) : 27'(pmag);
      end
      S_WID: begin
        if (mul_done) begin
          vd   <= v_val;
          flag <= flag | v_of;
        end
      end
      S_WIQ: begin
        if (mul_done) begin
          vq   <= v_val;
          flag <= flag | v_of;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_data.d_voltage <= vd;
          out_data.q_voltage <= vq;
          out_data.d_current <= id;
          out_data.q_current <= iq;
          out_data.saturated <= flag;
        end
      end
      default: ;
    endcase
  end

endmodule
